// ===== hdl/pbrd_pkg.sv =====
package pbrd_pkg;

	localparam int SAMPLE_BITS = 12;
	localparam int TIME_BITS   = 32;
	localparam int RATE_BITS   = 16;
	localparam int MIN_BITS    = 16;
	localparam int CFG_BITS    = 16;
	localparam int INDEX_BITS  = 2;

	localparam int DIV_W     = (TIME_BITS > RATE_BITS) ? TIME_BITS : RATE_BITS + 1;
	localparam int DIV_CNT_W = $clog2(RATE_BITS);

	localparam logic [RATE_BITS-1:0]   RATE_NUMERATOR = RATE_BITS'(60000);
	localparam logic [SAMPLE_BITS-1:0] TRIGGER_RESET  = SAMPLE_BITS'(2800);
	localparam logic [SAMPLE_BITS-1:0] RELEASE_RESET  = SAMPLE_BITS'(2500);
	localparam logic [MIN_BITS-1:0]    MIN_RESET      = MIN_BITS'(400);

	localparam logic [INDEX_BITS-1:0] REG_TRIGGER = INDEX_BITS'(0);
	localparam logic [INDEX_BITS-1:0] REG_RELEASE = INDEX_BITS'(1);
	localparam logic [INDEX_BITS-1:0] REG_MIN_INT = INDEX_BITS'(2);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIV,
		ST_DONE
	} state_t;

endpackage

// ===== hdl/pbrd_div.sv =====
module pbrd_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [pbrd_pkg::TIME_BITS-1:0]    divisor,
	output logic                              done,
	output logic [pbrd_pkg::RATE_BITS-1:0]    quotient
);

	logic [pbrd_pkg::TIME_BITS-1:0] div_q;
	logic [pbrd_pkg::RATE_BITS-1:0] rem_q;
	logic [pbrd_pkg::RATE_BITS-1:0] quo_q;
	logic [pbrd_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                           busy_q;
	logic                           done_q;

	logic [pbrd_pkg::DIV_W-1:0] trial;
	logic [pbrd_pkg::DIV_W-1:0] div_ext;
	logic [pbrd_pkg::DIV_W-1:0] diff;
	logic                       fits;

	always_comb begin
		trial   = pbrd_pkg::DIV_W'({rem_q, quo_q[pbrd_pkg::RATE_BITS-1]});
		div_ext = pbrd_pkg::DIV_W'(div_q);
		fits    = trial >= div_ext;
		diff    = trial - div_ext;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= pbrd_pkg::DIV_CNT_W'(pbrd_pkg::RATE_BITS - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - pbrd_pkg::DIV_CNT_W'(1);
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			div_q <= divisor;
			rem_q <= '0;
			quo_q <= pbrd_pkg::RATE_NUMERATOR;
		end else if (busy_q) begin
			rem_q <= fits ? diff[pbrd_pkg::RATE_BITS-1:0] : trial[pbrd_pkg::RATE_BITS-1:0];
			quo_q <= {quo_q[pbrd_pkg::RATE_BITS-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== hdl/pulse_beat_rate_detector.sv =====
// A sample that gives no beat passes from accept through the check and done states to the
// output register; an accepted beat also passes the divide state, where the divider forms the
// rate one quotient bit at a time. Words are taken one at a time; sample_stall is high from
// accept until the result is loaded into the output register, and the output register
// holds its word while result_stall is high.
// Reset (arst_n low, asynchronous): armed, last beat time 0, rate 0, levels 2800/2500,
// minimum interval 400 ms, no result pending.
module pulse_beat_rate_detector (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [pbrd_pkg::INDEX_BITS-1:0]    cfg_index,
	input  logic [pbrd_pkg::CFG_BITS-1:0]      cfg_data,
	input  logic                               sample_valid,
	output logic                               sample_stall,
	input  logic [pbrd_pkg::SAMPLE_BITS-1:0]   sample,
	input  logic [pbrd_pkg::TIME_BITS-1:0]     time_ms,
	output logic                               result_valid,
	input  logic                               result_stall,
	output logic [pbrd_pkg::RATE_BITS-1:0]     rate_bpm,
	output logic                               beat_latched,
	output logic                               beat_now
);

	pbrd_pkg::state_t state_q, state_d;

	logic [pbrd_pkg::SAMPLE_BITS-1:0] trigger_q;
	logic [pbrd_pkg::SAMPLE_BITS-1:0] release_q;
	logic [pbrd_pkg::MIN_BITS-1:0]    min_int_q;

	logic [pbrd_pkg::SAMPLE_BITS-1:0] sample_q;
	logic [pbrd_pkg::TIME_BITS-1:0]   time_q;
	logic [pbrd_pkg::TIME_BITS-1:0]   last_beat_q;
	logic [pbrd_pkg::RATE_BITS-1:0]   rate_q;
	logic                             latched_q;
	logic                             now_q;

	logic                             out_valid_q;
	logic [pbrd_pkg::RATE_BITS-1:0]   out_rate_q;
	logic                             out_latched_q;
	logic                             out_now_q;

	logic [pbrd_pkg::TIME_BITS-1:0]   interval;
	logic                             above;
	logic                             beat_ok;
	logic                             accept;
	logic                             out_free;
	logic                             div_start;
	logic                             div_done;
	logic [pbrd_pkg::RATE_BITS-1:0]   div_quo;
	logic                             load_out;

	assign accept   = sample_valid && !sample_stall;
	assign out_free = !out_valid_q || !result_stall;
	assign interval = time_q - last_beat_q;
	assign above    = (sample_q > trigger_q) && !latched_q;
	assign beat_ok  = above && (interval > pbrd_pkg::TIME_BITS'(min_int_q));

	pbrd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.divisor  (interval),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			pbrd_pkg::ST_IDLE:  if (accept) state_d = pbrd_pkg::ST_CHECK;
			pbrd_pkg::ST_CHECK: state_d = beat_ok ? pbrd_pkg::ST_DIV : pbrd_pkg::ST_DONE;
			pbrd_pkg::ST_DIV:   if (div_done) state_d = pbrd_pkg::ST_DONE;
			pbrd_pkg::ST_DONE:  if (out_free) state_d = pbrd_pkg::ST_IDLE;
			default:            state_d = pbrd_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		sample_stall = state_q != pbrd_pkg::ST_IDLE;
		div_start    = (state_q == pbrd_pkg::ST_CHECK) && beat_ok;
		load_out     = (state_q == pbrd_pkg::ST_DONE) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pbrd_pkg::ST_IDLE;
			trigger_q   <= pbrd_pkg::TRIGGER_RESET;
			release_q   <= pbrd_pkg::RELEASE_RESET;
			min_int_q   <= pbrd_pkg::MIN_RESET;
			last_beat_q <= '0;
			rate_q      <= '0;
			latched_q   <= 1'b0;
			now_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					pbrd_pkg::REG_TRIGGER: trigger_q <= cfg_data[pbrd_pkg::SAMPLE_BITS-1:0];
					pbrd_pkg::REG_RELEASE: release_q <= cfg_data[pbrd_pkg::SAMPLE_BITS-1:0];
					pbrd_pkg::REG_MIN_INT: min_int_q <= cfg_data[pbrd_pkg::MIN_BITS-1:0];
					default: ;
				endcase
			end
			if (state_q == pbrd_pkg::ST_CHECK) begin
				now_q <= 1'b0;
				if (!above && (sample_q < release_q))
					latched_q <= 1'b0;
			end
			if ((state_q == pbrd_pkg::ST_DIV) && div_done) begin
				rate_q      <= div_quo;
				last_beat_q <= time_q;
				latched_q   <= 1'b1;
				now_q       <= 1'b1;
			end
			if (load_out)
				out_valid_q <= 1'b1;
			else if (!result_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_q <= sample;
			time_q   <= time_ms;
		end
		if (load_out) begin
			out_rate_q    <= rate_q;
			out_latched_q <= latched_q;
			out_now_q     <= now_q;
		end
	end

	assign result_valid = out_valid_q;
	assign rate_bpm     = out_rate_q;
	assign beat_latched = out_latched_q;
	assign beat_now     = out_now_q;

	a_now_latched: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && beat_now |-> beat_latched)
		else $error("beat word without latched flag");

	a_rate_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && beat_now |-> rate_bpm <= pbrd_pkg::RATE_NUMERATOR)
		else $error("rate above numerator");

	a_div_in_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == pbrd_pkg::ST_DIV)
		else $error("divider finished outside divide state");

	a_accept_check: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == pbrd_pkg::ST_CHECK)
		else $error("accepted word not checked");

	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> result_valid)
		else $error("result word lost");

endmodule
